// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the framebuffer controller RTL.
// In synthesis builds the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define PFE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pfe assertion failed");

// The condition must never be true at a clock edge outside reset.
`define PFE_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pfe forbidden condition seen");

`else

`define PFE_ASSERT(name, clk, rst_n, prop)
`define PFE_ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

// ===== rtl/core/pfe_pkg.sv =====
package pfe_pkg;

  localparam int SCREEN_WIDTH  = 84;
  localparam int SCREEN_HEIGHT = 48;
  localparam int PAGE_ROWS     = 8;
  localparam int PAGE_COUNT    = SCREEN_HEIGHT / PAGE_ROWS;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;

  localparam int ADDR_W   = $clog2(STORE_BYTES);
  localparam int COLX_W   = $clog2(SCREEN_WIDTH);
  localparam int PAGE_W   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int COL_BITS = PAGE_COUNT * PAGE_ROWS;
  localparam int BYTE_W   = PAGE_ROWS;
  localparam int BIT_W    = $clog2(PAGE_ROWS);

  localparam int OP_W     = 3;
  localparam int PIX_W    = 8;
  localparam int SCROLL_W = 7;
  localparam int IDX_W    = 9;

  typedef enum logic [OP_W-1:0] {
    OP_SET    = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_FILL   = 3'd2,
    OP_SCROLL = 3'd3,
    OP_READ   = 3'd4
  } pfe_op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MEM_RD,
    ST_PIX_WR,
    ST_RD_CAP,
    ST_FILL,
    ST_SC_LOAD,
    ST_SC_WAIT,
    ST_SC_SHIFT,
    ST_SC_STORE,
    ST_DONE
  } pfe_state_e;

  typedef struct packed {
    logic                       valid;
    logic [OP_W-1:0]            opcode;
    logic [PIX_W-1:0]           pixel_x;
    logic [PIX_W-1:0]           pixel_y;
    logic [BYTE_W-1:0]          fill_value;
    logic signed [SCROLL_W-1:0] scroll_rows;
    logic [IDX_W-1:0]           read_index;
  } pfe_req_t;

  typedef struct packed {
    logic                load;
    logic [PAGE_W-1:0]   load_page;
    logic [BYTE_W-1:0]   load_byte;
    logic                shift;
    logic                up;
    logic [SCROLL_W-1:0] mag;
    logic [PAGE_W-1:0]   rd_page;
  } pfe_col_cmd_t;

  typedef struct packed {
    logic              done;
    logic [BYTE_W-1:0] data;
  } pfe_res_t;

  function automatic logic [BYTE_W-1:0] pfe_bitrev(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[i] = v[BYTE_W-1-i];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/pfe_ifs.sv =====
interface pfe_req_if;
  import pfe_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            opcode;
  logic [PIX_W-1:0]           pixel_x;
  logic [PIX_W-1:0]           pixel_y;
  logic [BYTE_W-1:0]          fill_value;
  logic signed [SCROLL_W-1:0] scroll_rows;
  logic [IDX_W-1:0]           read_index;

  modport source (
    output valid, opcode, pixel_x, pixel_y, fill_value, scroll_rows, read_index,
    input  ready
  );
  modport sink (
    input  valid, opcode, pixel_x, pixel_y, fill_value, scroll_rows, read_index,
    output ready
  );
endinterface

interface pfe_rsp_if;
  import pfe_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

interface pfe_cfg_if;
  logic valid;
  logic ready;
  logic rotate_180;

  modport source (output valid, rotate_180, input ready);
  modport sink (input valid, rotate_180, output ready);
endinterface

// ===== rtl/core/pfe_ram.sv =====
module pfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/pfe_colshift.sv =====
module pfe_colshift (
  input  logic                         clk_i,
  input  pfe_pkg::pfe_col_cmd_t        cmd_i,
  output logic [pfe_pkg::BYTE_W-1:0]   byte_o
);
  import pfe_pkg::*;

  // One column of the screen as a vector: bit y is pixel row y.
  logic [COL_BITS-1:0] col_q;
  logic [COL_BITS-1:0] col_d;

  always_comb begin
    col_d = col_q;
    if (cmd_i.shift) begin
      col_d = cmd_i.up ? (col_q >> cmd_i.mag) : (col_q << cmd_i.mag);
    end else if (cmd_i.load) begin
      col_d[int'(cmd_i.load_page) * BYTE_W +: BYTE_W] = cmd_i.load_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
  end

  assign byte_o = col_q[int'(cmd_i.rd_page) * BYTE_W +: BYTE_W];

endmodule

// ===== rtl/core/pfe_ctrl.sv =====
`include "assert_macros.svh"

module pfe_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pfe_pkg::pfe_req_t          req_i,
  output logic                       req_ready_o,
  input  logic                       rotate_i,
  input  logic                       slot_free_i,
  output pfe_pkg::pfe_res_t          res_o,
  output logic                       ram_we_o,
  output logic [pfe_pkg::ADDR_W-1:0] ram_waddr_o,
  output logic [pfe_pkg::BYTE_W-1:0] ram_wdata_o,
  output logic                       ram_re_o,
  output logic [pfe_pkg::ADDR_W-1:0] ram_raddr_o,
  input  logic [pfe_pkg::BYTE_W-1:0] ram_rdata_i,
  output pfe_pkg::pfe_col_cmd_t      col_cmd_o,
  input  logic [pfe_pkg::BYTE_W-1:0] col_byte_i
);
  import pfe_pkg::*;

  pfe_state_e          state_q, state_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [COLX_W-1:0]   colx_q, colx_d;
  logic [PAGE_W-1:0]   page_q, page_d;
  logic                ld_vld_q, ld_vld_d;
  logic [PAGE_W-1:0]   ld_page_q, ld_page_d;
  logic [BYTE_W-1:0]   fill_q, fill_d;
  logic [OP_W-1:0]     op_q, op_d;
  logic [BIT_W-1:0]    bit_q, bit_d;
  logic                up_q, up_d;
  logic [SCROLL_W-1:0] mag_q, mag_d;
  logic [BYTE_W-1:0]   result_q, result_d;

  logic                pix_ok;
  logic                rd_ok;
  logic [ADDR_W-1:0]   pix_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic [SCROLL_W-1:0] raw;
  logic [BYTE_W-1:0]   mask;
  logic [ADDR_W-1:0]   next_col;

  assign pix_ok = (int'(req_i.pixel_x) < SCREEN_WIDTH)
               && (int'(req_i.pixel_y) < SCREEN_HEIGHT)
               && (int'(req_i.pixel_y) < PAGE_COUNT * PAGE_ROWS);
  assign pix_addr = ADDR_W'(int'(req_i.pixel_x)
                  + SCREEN_WIDTH * int'(req_i.pixel_y[PIX_W-1:BIT_W]));
  assign rd_ok = int'(req_i.read_index) < STORE_BYTES;
  assign rd_addr = rotate_i ? ADDR_W'(STORE_BYTES - 1 - int'(req_i.read_index))
                            : ADDR_W'(req_i.read_index);
  assign raw = req_i.scroll_rows;
  assign mask = BYTE_W'(1) << bit_q;
  assign next_col = ADDR_W'(colx_q) + ADDR_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      addr_q   <= '0;
      colx_q   <= '0;
      page_q   <= '0;
      ld_vld_q <= 1'b0;
      fill_q   <= '0;
      op_q     <= '0;
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      colx_q   <= colx_d;
      page_q   <= page_d;
      ld_vld_q <= ld_vld_d;
      fill_q   <= fill_d;
      op_q     <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ld_page_q <= ld_page_d;
    bit_q     <= bit_d;
    up_q      <= up_d;
    mag_q     <= mag_d;
    result_q  <= result_d;
  end

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    colx_d      = colx_q;
    page_d      = page_q;
    ld_vld_d    = 1'b0;
    ld_page_d   = page_q;
    fill_d      = fill_q;
    op_d        = op_q;
    bit_d       = bit_q;
    up_d        = up_q;
    mag_d       = mag_q;
    result_d    = result_q;
    req_ready_o = 1'b0;
    res_o       = '{done: 1'b0, data: result_q};
    ram_we_o    = 1'b0;
    ram_waddr_o = addr_q;
    ram_wdata_o = fill_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = addr_q;

    col_cmd_o.load      = ld_vld_q;
    col_cmd_o.load_page = ld_page_q;
    col_cmd_o.load_byte = ram_rdata_i;
    col_cmd_o.shift     = 1'b0;
    col_cmd_o.up        = up_q;
    col_cmd_o.mag       = mag_q;
    col_cmd_o.rd_page   = page_q;

    case (state_q)
      // Zero the store once after reset, one byte per cycle.
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = '0;
        addr_d      = addr_q + ADDR_W'(1);
        if (addr_q == ADDR_W'(STORE_BYTES - 1)) begin
          addr_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_i.valid) begin
          op_d     = req_i.opcode;
          result_d = '0;
          state_d  = ST_DONE;
          case (pfe_op_e'(req_i.opcode))
            OP_SET, OP_CLEAR: begin
              addr_d = pix_addr;
              bit_d  = req_i.pixel_y[BIT_W-1:0];
              if (pix_ok) begin
                state_d = ST_MEM_RD;
              end
            end
            OP_FILL: begin
              fill_d  = req_i.fill_value;
              addr_d  = '0;
              state_d = ST_FILL;
            end
            OP_SCROLL: begin
              up_d    = !raw[SCROLL_W-1] && (raw != '0);
              mag_d   = raw[SCROLL_W-1] ? SCROLL_W'(~raw + SCROLL_W'(1)) : raw;
              addr_d  = '0;
              colx_d  = '0;
              page_d  = '0;
              state_d = ST_SC_LOAD;
            end
            OP_READ: begin
              addr_d = rd_addr;
              if (rd_ok) begin
                state_d = ST_MEM_RD;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_MEM_RD: begin
        ram_re_o = 1'b1;
        state_d  = (pfe_op_e'(op_q) == OP_READ) ? ST_RD_CAP : ST_PIX_WR;
      end
      ST_PIX_WR: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = (pfe_op_e'(op_q) == OP_SET) ? (ram_rdata_i | mask)
                                                  : (ram_rdata_i & ~mask);
        state_d     = ST_DONE;
      end
      ST_RD_CAP: begin
        result_d = rotate_i ? pfe_bitrev(ram_rdata_i) : ram_rdata_i;
        state_d  = ST_DONE;
      end
      ST_FILL: begin
        ram_we_o = 1'b1;
        addr_d   = addr_q + ADDR_W'(1);
        if (addr_q == ADDR_W'(STORE_BYTES - 1)) begin
          state_d = ST_DONE;
        end
      end
      // Read the pages of one column; each byte passes through the store's read
      // register before it is loaded into the column register.
      ST_SC_LOAD: begin
        ram_re_o  = 1'b1;
        ld_vld_d  = 1'b1;
        ld_page_d = page_q;
        addr_d    = addr_q + ADDR_W'(SCREEN_WIDTH);
        page_d    = page_q + PAGE_W'(1);
        if (page_q == PAGE_W'(PAGE_COUNT - 1)) begin
          addr_d  = ADDR_W'(colx_q);
          page_d  = '0;
          state_d = ST_SC_WAIT;
        end
      end
      ST_SC_WAIT: begin
        state_d = ST_SC_SHIFT;
      end
      ST_SC_SHIFT: begin
        col_cmd_o.shift = 1'b1;
        state_d         = ST_SC_STORE;
      end
      ST_SC_STORE: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = col_byte_i;
        addr_d      = addr_q + ADDR_W'(SCREEN_WIDTH);
        page_d      = page_q + PAGE_W'(1);
        if (page_q == PAGE_W'(PAGE_COUNT - 1)) begin
          page_d = '0;
          if (colx_q == COLX_W'(SCREEN_WIDTH - 1)) begin
            state_d = ST_DONE;
          end else begin
            colx_d  = colx_q + COLX_W'(1);
            addr_d  = next_col;
            state_d = ST_SC_LOAD;
          end
        end
      end
      ST_DONE: begin
        if (slot_free_i) begin
          res_o.done = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `PFE_ASSERT(a_wr_addr_range, clk_i, rst_ni, ram_we_o |-> (int'(ram_waddr_o) < STORE_BYTES))
  `PFE_ASSERT(a_rd_addr_range, clk_i, rst_ni, ram_re_o |-> (int'(ram_raddr_o) < STORE_BYTES))
  `PFE_ASSERT(a_busy_after_accept, clk_i, rst_ni, (req_i.valid && req_ready_o) |=> !req_ready_o)
  `PFE_ASSERT_NEVER(a_no_rw_overlap, clk_i, rst_ni, ram_we_o && ram_re_o)

endmodule

// ===== rtl/core/page_framebuffer_engine_unit.sv =====
// Channel | Dir | Payload                                         | Accepted when
// in_i    | in  | opcode, pixel_x/y, fill_value, scroll_rows,     | valid && ready
//         |     | read_index                                      |
// out_o   | out | read_data                                       | valid && ready
// cfg_i   | in  | rotate_180                                      | valid && ready
//
// Every request walks a sequencer around one registered-read byte store: set, clear
// and read finish at once off screen, past the end or for an unused opcode; scroll
// walks 84 columns of 6 reads, a wait, one column shift and 6 writes.
// After reset a clearing pass zeroes the store before in_i is ready.
// The result sits in an output register, so a new request is taken while it
// waits; a finished request holds its sequencer until that register is free.
module page_framebuffer_engine_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  pfe_req_if.sink    in_i,
  pfe_rsp_if.source  out_o,
  pfe_cfg_if.sink    cfg_i
);
  import pfe_pkg::*;

  logic              rotate_q;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_data_q, out_data_d;
  logic              slot_free;
  pfe_req_t          req;
  pfe_res_t          res;
  pfe_col_cmd_t      col_cmd;
  logic [BYTE_W-1:0] col_byte;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  assign req = '{
    valid:       in_i.valid,
    opcode:      in_i.opcode,
    pixel_x:     in_i.pixel_x,
    pixel_y:     in_i.pixel_y,
    fill_value:  in_i.fill_value,
    scroll_rows: in_i.scroll_rows,
    read_index:  in_i.read_index
  };

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotate_q <= 1'b0;
    end else if (cfg_i.valid) begin
      rotate_q <= cfg_i.rotate_180;
    end
  end

  assign slot_free = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res.done) begin
      out_valid_d = 1'b1;
      out_data_d  = res.data;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = out_data_q;

  pfe_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pfe_colshift u_colshift (
    .clk_i  (clk_i),
    .cmd_i  (col_cmd),
    .byte_o (col_byte)
  );

  pfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .req_ready_o (in_i.ready),
    .rotate_i    (rotate_q),
    .slot_free_i (slot_free),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .col_cmd_o   (col_cmd),
    .col_byte_i  (col_byte)
  );

endmodule
